/* hw/rtl/mmrt_pkg.sv */
// ----------------------------------------------------------------------------
// mmrt_pkg
// Shared types, codes and helper functions of the masked register table.
// ----------------------------------------------------------------------------
package mmrt_pkg;

  localparam int AddrW     = 64;
  localparam int DataW     = 64;
  localparam int OpW       = 3;
  localparam int SizeW     = 2;
  localparam int StatusW   = 2;
  localparam int HalfShift = 32;
  localparam int InTdataW  = 200;
  localparam int OutTdataW = 72;

  localparam logic [DataW-1:0] ByteMask = 64'h0000_0000_0000_00ff;
  localparam logic [DataW-1:0] HalfMask = 64'h0000_0000_0000_ffff;
  localparam logic [DataW-1:0] WordMask = 64'h0000_0000_ffff_ffff;
  localparam logic [DataW-1:0] FullMask = 64'hffff_ffff_ffff_ffff;

  typedef enum logic [OpW-1:0] {
    OP_DEFINE = 3'd0,
    OP_READ   = 3'd1,
    OP_WRITE  = 3'd2,
    OP_POKE   = 3'd3,
    OP_CHECK  = 3'd4
  } op_e;

  typedef enum logic [SizeW-1:0] {
    SIZE_BYTE   = 2'd0,
    SIZE_HALF   = 2'd1,
    SIZE_WORD   = 2'd2,
    SIZE_DOUBLE = 2'd3
  } size_e;

  typedef enum logic [StatusW-1:0] {
    STS_OK         = 2'd0,
    STS_MISALIGNED = 2'd1,
    STS_NO_REG     = 2'd2,
    STS_BAD        = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_LOOK,
    FSM_EXEC,
    FSM_WR2
  } state_e;

  typedef struct packed {
    logic [DataW-1:0] mask;
    logic [DataW-1:0] value;
  } entry_t;

  typedef struct packed {
    logic hit0;
    logic hit1;
    logic hit2;
    logic free;
    logic dbl0;
  } tag_hit_t;

  typedef struct packed {
    logic             en;
    logic             dbl;
    logic [AddrW-1:0] addr;
  } tag_wr_t;

  function automatic logic [DataW-1:0] width_mask(input logic [SizeW-1:0] sz);
    logic [DataW-1:0] m;
    unique case (sz)
      SIZE_BYTE: m = ByteMask;
      SIZE_HALF: m = HalfMask;
      SIZE_WORD: m = WordMask;
      default:   m = FullMask;
    endcase
    return m;
  endfunction

  function automatic logic [2:0] align_mask(input logic [SizeW-1:0] sz);
    logic [2:0] m;
    unique case (sz)
      SIZE_BYTE: m = 3'b000;
      SIZE_HALF: m = 3'b001;
      SIZE_WORD: m = 3'b011;
      default:   m = 3'b111;
    endcase
    return m;
  endfunction

  function automatic logic [DataW-1:0] masked_write(input entry_t e,
                                                    input logic [DataW-1:0] bytes,
                                                    input logic [DataW-1:0] data);
    logic [DataW-1:0] m;
    m = bytes & e.mask;
    return (e.value & ~m) | (data & m);
  endfunction

endpackage

/* hw/rtl/mmrt_tags.sv */
// ----------------------------------------------------------------------------
// mmrt_tags
// Entry tags: valid bits, addresses and size flags, with parallel address
// match against three lookup keys and lowest free slot search.
// ----------------------------------------------------------------------------
module mmrt_tags #(
  parameter int NUM_REGS = 16,
  parameter int IdxW     = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [mmrt_pkg::AddrW-1:0] key0_i,
  input  logic [mmrt_pkg::AddrW-1:0] key1_i,
  input  logic [mmrt_pkg::AddrW-1:0] key2_i,
  input  mmrt_pkg::tag_wr_t          wr_i,
  input  logic [IdxW-1:0]            widx_i,
  output mmrt_pkg::tag_hit_t         hit_o,
  output logic [IdxW-1:0]            idx0_o,
  output logic [IdxW-1:0]            idx1_o,
  output logic [IdxW-1:0]            idx2_o,
  output logic [IdxW-1:0]            free_idx_o
);

  logic [NUM_REGS-1:0]       valid_q;
  logic [NUM_REGS-1:0]       dbl_q;
  logic [mmrt_pkg::AddrW-1:0] addr_q [NUM_REGS];
  logic [NUM_REGS-1:0]       m0, m1, m2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      valid_q[widx_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      addr_q[widx_i] <= wr_i.addr;
      dbl_q[widx_i]  <= wr_i.dbl;
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_REGS; k++) begin
      m0[k] = valid_q[k] && (addr_q[k] == key0_i);
      m1[k] = valid_q[k] && (addr_q[k] == key1_i);
      m2[k] = valid_q[k] && (addr_q[k] == key2_i);
    end
  end

  // lowest index wins
  always_comb begin
    idx0_o     = '0;
    idx1_o     = '0;
    idx2_o     = '0;
    free_idx_o = '0;
    for (int k = NUM_REGS - 1; k >= 0; k--) begin
      if (m0[k]) idx0_o = IdxW'(k);
      if (m1[k]) idx1_o = IdxW'(k);
      if (m2[k]) idx2_o = IdxW'(k);
      if (!valid_q[k]) free_idx_o = IdxW'(k);
    end
    hit_o.hit0 = |m0;
    hit_o.hit1 = |m1;
    hit_o.hit2 = |m2;
    hit_o.free = ~&valid_q;
    hit_o.dbl0 = |(m0 & dbl_q);
  end

endmodule

/* hw/rtl/mmrt_mem.sv */
// ----------------------------------------------------------------------------
// mmrt_mem
// Entry store for mask and value: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module mmrt_mem #(
  parameter int DEPTH = 16,
  parameter int IdxW  = 4
) (
  input  logic                clk_i,
  input  logic [IdxW-1:0]     raddr_a_i,
  input  logic [IdxW-1:0]     raddr_b_i,
  output mmrt_pkg::entry_t    rdata_a_o,
  output mmrt_pkg::entry_t    rdata_b_o,
  input  logic                we_i,
  input  logic [IdxW-1:0]     waddr_i,
  input  mmrt_pkg::entry_t    wdata_i
);

  mmrt_pkg::entry_t mem [DEPTH];
  mmrt_pkg::entry_t rdata_a_q;
  mmrt_pkg::entry_t rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem[raddr_a_i];
    rdata_b_q <= mem[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

/* hw/rtl/masked_mmio_register_table.sv */
// ----------------------------------------------------------------------------
// masked_mmio_register_table
// Table of memory-mapped registers with per-bit write masks.
// ----------------------------------------------------------------------------
// One beat in, one beat out. Each operation (define, read, write, poke,
// check) goes through a lookup step, for the tag match and the entry memory
// read, and an execute step, which builds the result, registers it onto the
// output and writes back. The next input beat is taken in the idle state
// that follows. A double-word write to a 4-byte entry that has a neighbor
// at address+4 adds a second write-back step, since the entry memory has a
// single write port. A new beat is taken once the previous one has been
// written back; a result that is not yet taken stalls the next one only at
// its write-back step.
module masked_mmio_register_table #(
  parameter int NUM_REGS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // address, access_size, write_data, reg_mask, zero pad
  input  logic [mmrt_pkg::InTdataW-1:0]       s_axis_tdata_i,
  // opcode
  input  logic [mmrt_pkg::OpW-1:0]            s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // status, read_data, zero pad
  output logic [mmrt_pkg::OutTdataW-1:0]      m_axis_tdata_o
);

  localparam int IdxW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  mmrt_pkg::state_e state_q, state_d;

  logic [mmrt_pkg::OpW-1:0]   op_q;
  logic [mmrt_pkg::AddrW-1:0] addr_q;
  logic [mmrt_pkg::SizeW-1:0] sz_q;
  logic [mmrt_pkg::DataW-1:0] data_q;
  logic [mmrt_pkg::DataW-1:0] rmask_q;

  mmrt_pkg::tag_hit_t hit, hit_q;
  logic [IdxW-1:0]    idx0, idx1, idx2, free_idx;
  logic [IdxW-1:0]    sel_idx_q, j_idx_q, def_idx_q;
  logic [IdxW-1:0]    raddr_a;

  logic [mmrt_pkg::AddrW-1:0] key0, key1, key2;

  mmrt_pkg::entry_t ent_a, ent_b;

  logic                          s_ready, exec_go, wr2_go, out_free;
  logic                          need_wr2;
  logic [mmrt_pkg::StatusW-1:0]  ex_status;
  logic [mmrt_pkg::DataW-1:0]    ex_rdata;
  logic                          ex_we;
  logic [IdxW-1:0]               ex_widx;
  mmrt_pkg::entry_t              ex_wdata;
  mmrt_pkg::entry_t              wr2_d;
  mmrt_pkg::tag_wr_t             ex_tag_wr, tag_wr;

  mmrt_pkg::entry_t   wr2_q;
  logic               out_valid_q;
  logic [mmrt_pkg::StatusW-1:0] out_status_q;
  logic [mmrt_pkg::DataW-1:0]   out_rdata_q;

  logic                 mem_we;
  logic [IdxW-1:0]      mem_waddr;
  mmrt_pkg::entry_t     mem_wdata;

  // input capture
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_ready) begin
      op_q    <= s_axis_tuser_i;
      addr_q  <= s_axis_tdata_i[63:0];
      sz_q    <= s_axis_tdata_i[65:64];
      data_q  <= s_axis_tdata_i[129:66];
      rmask_q <= s_axis_tdata_i[193:130];
    end
  end

  assign key0 = {addr_q[mmrt_pkg::AddrW-1:2], 2'b00};
  assign key1 = {addr_q[mmrt_pkg::AddrW-1:3], 3'b000};
  assign key2 = addr_q + mmrt_pkg::AddrW'(4);

  mmrt_tags #(
    .NUM_REGS (NUM_REGS),
    .IdxW     (IdxW)
  ) u_tags (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .key0_i     (key0),
    .key1_i     (key1),
    .key2_i     (key2),
    .wr_i       (tag_wr),
    .widx_i     (def_idx_q),
    .hit_o      (hit),
    .idx0_o     (idx0),
    .idx1_o     (idx1),
    .idx2_o     (idx2),
    .free_idx_o (free_idx)
  );

  assign raddr_a = hit.hit0 ? idx0 : idx1;

  // lookup results for the execute step
  always_ff @(posedge clk_i) begin
    if (state_q == mmrt_pkg::FSM_LOOK) begin
      hit_q     <= hit;
      sel_idx_q <= raddr_a;
      j_idx_q   <= idx2;
      def_idx_q <= hit.hit0 ? idx0 : free_idx;
    end
  end

  mmrt_mem #(
    .DEPTH (NUM_REGS),
    .IdxW  (IdxW)
  ) u_mem (
    .clk_i     (clk_i),
    .raddr_a_i (raddr_a),
    .raddr_b_i (idx2),
    .rdata_a_o (ent_a),
    .rdata_b_o (ent_b),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata)
  );

  // execute datapath
  always_comb begin
    logic                       mis;
    logic                       sub_found;
    logic [5:0]                 sh;
    logic [mmrt_pkg::DataW-1:0] wm;
    logic [mmrt_pkg::DataW-1:0] bm;
    logic                       pair;

    mis       = |(addr_q[2:0] & mmrt_pkg::align_mask(sz_q));
    sub_found = hit_q.hit0 | hit_q.hit1;
    sh        = hit_q.hit0 ? {1'b0, addr_q[1:0], 3'b000} : {addr_q[2:0], 3'b000};
    wm        = mmrt_pkg::width_mask(sz_q);
    bm        = mmrt_pkg::ByteMask << sh;
    pair      = !hit_q.dbl0 && hit_q.hit2;

    ex_status = mmrt_pkg::STS_OK;
    ex_rdata  = '0;
    ex_we     = 1'b0;
    ex_widx   = sel_idx_q;
    ex_wdata  = ent_a;
    need_wr2  = 1'b0;
    wr2_d     = ent_b;
    ex_tag_wr = '{en: 1'b0, dbl: (sz_q == mmrt_pkg::SIZE_DOUBLE), addr: addr_q};

    unique case (op_q)
      mmrt_pkg::OP_DEFINE: begin
        if (sz_q == mmrt_pkg::SIZE_BYTE || sz_q == mmrt_pkg::SIZE_HALF) begin
          ex_status = mmrt_pkg::STS_BAD;
        end else if (mis) begin
          ex_status = mmrt_pkg::STS_MISALIGNED;
        end else if (!(hit_q.hit0 || hit_q.free)) begin
          ex_status = mmrt_pkg::STS_BAD;
        end else begin
          ex_tag_wr.en   = 1'b1;
          ex_we          = 1'b1;
          ex_widx        = def_idx_q;
          ex_wdata.mask  = rmask_q;
          ex_wdata.value = '0;
        end
      end
      mmrt_pkg::OP_READ, mmrt_pkg::OP_WRITE, mmrt_pkg::OP_CHECK: begin
        if (mis) begin
          ex_status = mmrt_pkg::STS_MISALIGNED;
        end else if (sz_q == mmrt_pkg::SIZE_DOUBLE) begin
          if (!hit_q.hit0) begin
            ex_status = mmrt_pkg::STS_NO_REG;
          end else if (op_q == mmrt_pkg::OP_READ) begin
            ex_rdata = ent_a.value;
            if (pair) begin
              ex_rdata = ent_a.value | (ent_b.value << mmrt_pkg::HalfShift);
            end
          end else if (op_q == mmrt_pkg::OP_WRITE) begin
            ex_we          = 1'b1;
            ex_wdata.value = mmrt_pkg::masked_write(ent_a, mmrt_pkg::FullMask, data_q);
            need_wr2       = pair;
            wr2_d.value    = mmrt_pkg::masked_write(ent_b, mmrt_pkg::WordMask,
                                                    data_q >> mmrt_pkg::HalfShift);
          end
        end else begin
          if (!sub_found) begin
            ex_status = mmrt_pkg::STS_NO_REG;
          end else if (op_q == mmrt_pkg::OP_READ) begin
            ex_rdata = (ent_a.value >> sh) & wm;
          end else if (op_q == mmrt_pkg::OP_WRITE) begin
            ex_we          = 1'b1;
            ex_wdata.value = mmrt_pkg::masked_write(ent_a, wm << sh, (data_q & wm) << sh);
          end
        end
      end
      mmrt_pkg::OP_POKE: begin
        if (!sub_found) begin
          ex_status = mmrt_pkg::STS_NO_REG;
        end else begin
          ex_we          = 1'b1;
          ex_wdata.value = (ent_a.value & ~bm) | ((data_q & mmrt_pkg::ByteMask) << sh);
        end
      end
      default: begin
        ex_status = mmrt_pkg::STS_BAD;
      end
    endcase
  end

  assign out_free = !out_valid_q || m_axis_tready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mmrt_pkg::FSM_IDLE: if (s_axis_tvalid_i) state_d = mmrt_pkg::FSM_LOOK;
      mmrt_pkg::FSM_LOOK: state_d = mmrt_pkg::FSM_EXEC;
      mmrt_pkg::FSM_EXEC: begin
        if (out_free) state_d = need_wr2 ? mmrt_pkg::FSM_WR2 : mmrt_pkg::FSM_IDLE;
      end
      mmrt_pkg::FSM_WR2:  state_d = mmrt_pkg::FSM_IDLE;
      default:            state_d = mmrt_pkg::FSM_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_ready = (state_q == mmrt_pkg::FSM_IDLE);
    exec_go = (state_q == mmrt_pkg::FSM_EXEC) && out_free;
    wr2_go  = (state_q == mmrt_pkg::FSM_WR2);
  end

  always_comb begin
    tag_wr    = ex_tag_wr;
    tag_wr.en = ex_tag_wr.en && exec_go;
    mem_we    = (ex_we && exec_go) || wr2_go;
    mem_waddr = wr2_go ? j_idx_q : ex_widx;
    mem_wdata = wr2_go ? wr2_q : ex_wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mmrt_pkg::FSM_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (exec_go) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_go) begin
      out_status_q <= ex_status;
      out_rdata_q  <= ex_rdata;
      wr2_q        <= wr2_d;
    end
  end

  assign s_axis_tready_o = s_ready;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, out_rdata_q, out_status_q};

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Stream-level testbench of the masked register table. A directed opening
// walks the corner cases of define, read, write, poke and check, then random
// accesses aimed at two small address windows fill and exercise the table.
// A scoreboard class keeps its own copy of the table, predicts the status and
// read data of every accepted beat and compares each returned beat in order.
// ----------------------------------------------------------------------------
module tb;
  import mmrt_pkg::*;

  localparam int                NumRegs     = 16;
  localparam int                NumRandom   = 1700;
  localparam int                QuietLimit  = 1000;
  localparam int                DrainCycles = 10;
  localparam int                MaxReports  = 10;
  localparam logic [OpW-1:0]    OpUnusedLo  = 3'd5;
  localparam logic [OpW-1:0]    OpUnusedHi  = 3'd7;
  localparam logic [AddrW-1:0]  TopDouble   = 64'hffff_ffff_ffff_fff8;
  localparam logic [AddrW-1:0]  HighWindow  = 64'hffff_ffff_ffff_ffc0;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [AddrW-1:0] addr;
    logic [SizeW-1:0] size;
    logic [DataW-1:0] wdata;
    logic [DataW-1:0] rmask;
  } access_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [DataW-1:0]   data;
  } reply_t;

  class reg_table_scoreboard;
    bit               live[NumRegs];
    bit               reg_dbl[NumRegs];
    logic [AddrW-1:0] reg_addr[NumRegs];
    logic [DataW-1:0] reg_wmask[NumRegs];
    logic [DataW-1:0] reg_value[NumRegs];
    reply_t           pending_replies[$];
    int               mismatches;
    int               replies_checked;
    int               ops_seen[8];
    int               status_seen[4];

    function new();
      foreach (live[i]) live[i] = 1'b0;
      foreach (ops_seen[i]) ops_seen[i] = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      mismatches      = 0;
      replies_checked = 0;
    endfunction

    function int find_reg(input logic [AddrW-1:0] a);
      for (int i = 0; i < NumRegs; i++)
        if (live[i] && reg_addr[i] == a) return i;
      return -1;
    endfunction

    // word-aligned entry first, then double-aligned
    function int find_sub(input logic [AddrW-1:0] a, output logic [AddrW-1:0] base);
      int idx;
      base = {a[AddrW-1:2], 2'b00};
      idx  = find_reg(base);
      if (idx < 0) begin
        base = {a[AddrW-1:3], 3'b000};
        idx  = find_reg(base);
      end
      return idx;
    endfunction

    function void merge(input int i, input logic [DataW-1:0] bytes,
                        input logic [DataW-1:0] data);
      logic [DataW-1:0] m;
      m = bytes & reg_wmask[i];
      reg_value[i] = (reg_value[i] & ~m) | (data & m);
    endfunction

    function void note_access(input access_t acc);
      reply_t           r;
      int               i;
      int               j;
      logic [AddrW-1:0] base;
      logic [DataW-1:0] wm;
      logic [DataW-1:0] bm;
      logic [5:0]       sh;
      logic [2:0]       low;
      r.status = STS_OK;
      r.data   = '0;
      low = 3'((4'd1 << acc.size) - 4'd1);
      wm  = (acc.size == SIZE_DOUBLE) ? FullMask : ((64'd1 << (7'd8 << acc.size)) - 64'd1);
      ops_seen[acc.op]++;
      case (acc.op)
        OP_DEFINE: begin
          if (acc.size < SIZE_WORD) begin
            r.status = STS_BAD;
          end else if ((acc.addr[2:0] & low) != 3'd0) begin
            r.status = STS_MISALIGNED;
          end else begin
            i = find_reg(acc.addr);
            if (i < 0)
              for (j = 0; j < NumRegs && i < 0; j++)
                if (!live[j]) i = j;
            if (i < 0) begin
              r.status = STS_BAD;
            end else begin
              live[i]      = 1'b1;
              reg_addr[i]  = acc.addr;
              reg_wmask[i] = acc.rmask;
              reg_dbl[i]   = (acc.size == SIZE_DOUBLE);
              reg_value[i] = '0;
            end
          end
        end
        OP_READ, OP_WRITE, OP_CHECK: begin
          if ((acc.addr[2:0] & low) != 3'd0) begin
            r.status = STS_MISALIGNED;
          end else if (acc.size == SIZE_DOUBLE) begin
            i = find_reg(acc.addr);
            if (i < 0) begin
              r.status = STS_NO_REG;
            end else begin
              j = reg_dbl[i] ? -1 : find_reg(acc.addr + 64'd4);
              if (acc.op == OP_READ) begin
                r.data = reg_value[i];
                if (j >= 0) r.data = r.data | (reg_value[j] << HalfShift);
              end else if (acc.op == OP_WRITE) begin
                merge(i, FullMask, acc.wdata);
                if (j >= 0) merge(j, WordMask, acc.wdata >> HalfShift);
              end
            end
          end else begin
            i = find_sub(acc.addr, base);
            if (i < 0) begin
              r.status = STS_NO_REG;
            end else begin
              sh = {3'(acc.addr[2:0] - base[2:0]), 3'b000};
              if (acc.op == OP_READ)
                r.data = (reg_value[i] >> sh) & wm;
              else if (acc.op == OP_WRITE)
                merge(i, wm << sh, (acc.wdata & wm) << sh);
            end
          end
        end
        OP_POKE: begin
          i = find_sub(acc.addr, base);
          if (i < 0) begin
            r.status = STS_NO_REG;
          end else begin
            sh = {3'(acc.addr[2:0] - base[2:0]), 3'b000};
            bm = ByteMask << sh;
            reg_value[i] = (reg_value[i] & ~bm) | ((acc.wdata & ByteMask) << sh);
          end
        end
        default: r.status = STS_BAD;
      endcase
      status_seen[r.status]++;
      pending_replies.push_back(r);
    endfunction

    function void check_response(input logic [StatusW-1:0] st, input logic [DataW-1:0] rd);
      reply_t want;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("unexpected result beat: status %0d data %h", st, rd);
        return;
      end
      want = pending_replies.pop_front();
      replies_checked++;
      if (st !== want.status || rd !== want.data) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("result %0d mismatch: status exp %0d got %0d, data exp %h got %h",
                   replies_checked, want.status, st, want.data, rd);
      end
    endfunction

    function int outstanding();
      return pending_replies.size();
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni          = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  // address, access_size, write_data, reg_mask, zero pad
  logic [InTdataW-1:0]  s_axis_tdata_i  = '0;
  // opcode
  logic [OpW-1:0]       s_axis_tuser_i  = '0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  // status, read_data, zero pad
  logic [OutTdataW-1:0] m_axis_tdata_o;

  reg_table_scoreboard sb;
  bit                  pacing = 1'b1;
  int                  quiet_cycles = 0;

  masked_mmio_register_table #(.NUM_REGS(NumRegs)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_access(input access_t acc);
    int gap;
    gap = pacing ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {6'd0, acc.rmask, acc.wdata, acc.size, acc.addr};
    s_axis_tuser_i  <= acc.op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_access(acc);
  endtask

  task automatic send_op(input logic [OpW-1:0] op, input logic [AddrW-1:0] addr,
                         input logic [SizeW-1:0] size, input logic [DataW-1:0] wdata,
                         input logic [DataW-1:0] rmask);
    access_t acc;
    acc = '{op: op, addr: addr, size: size, wdata: wdata, rmask: rmask};
    send_access(acc);
  endtask

  function automatic logic [DataW-1:0] pick_pattern();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return FullMask;
    return {$urandom, $urandom};
  endfunction

  function automatic access_t random_access();
    access_t acc;
    int      r;
    r = $urandom_range(0, 99);
    if (r < 18)      acc.op = OP_DEFINE;
    else if (r < 43) acc.op = OP_READ;
    else if (r < 68) acc.op = OP_WRITE;
    else if (r < 80) acc.op = OP_POKE;
    else if (r < 96) acc.op = OP_CHECK;
    else             acc.op = 3'($urandom_range(OpUnusedLo, OpUnusedHi));
    acc.size = 2'($urandom_range(0, 3));
    if (acc.op == OP_DEFINE && $urandom_range(0, 3) != 0)
      acc.size = $urandom_range(0, 1) ? SIZE_DOUBLE : SIZE_WORD;
    r = $urandom_range(0, 99);
    if (r < 45)      acc.addr = 64'($urandom_range(0, 63));
    else if (r < 90) acc.addr = HighWindow + 64'($urandom_range(0, 63));
    else             acc.addr = {$urandom, $urandom};
    if ($urandom_range(0, 4) != 0)
      acc.addr = acc.addr & ~((64'd1 << acc.size) - 64'd1);
    acc.wdata = pick_pattern();
    acc.rmask = pick_pattern();
    return acc;
  endfunction

  initial begin
    logic [StatusW-1:0] st;
    logic [DataW-1:0]   rd;
    wait (rst_ni);
    forever begin
      int stall;
      stall = pacing ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      st = m_axis_tdata_o[StatusW-1:0];
      rd = m_axis_tdata_o[StatusW +: DataW];
      sb.check_response(st, rd);
    end
  end

  initial begin
    int leftover;
    sb = new();
    wait (rst_ni);
    @(posedge clk_i);

    send_op(OP_DEFINE, 64'h0,  SIZE_WORD,   '0, FullMask);
    send_op(OP_DEFINE, 64'h8,  SIZE_DOUBLE, '0, 64'h00ff_00ff_f0f0_ffff);
    send_op(OP_DEFINE, 64'h4,  SIZE_WORD,   '0, 64'h0000_0000_ffff_0000);
    send_op(OP_DEFINE, 64'h2,  SIZE_WORD,   '0, FullMask);
    send_op(OP_DEFINE, 64'h20, SIZE_BYTE,   '0, FullMask);
    send_op(OP_DEFINE, 64'h20, SIZE_HALF,   '0, FullMask);
    send_op(OP_WRITE,  64'h0,  SIZE_DOUBLE, FullMask, '0);
    send_op(OP_READ,   64'h0,  SIZE_DOUBLE, '0, '0);
    send_op(OP_READ,   64'h3,  SIZE_BYTE,   '0, '0);
    send_op(OP_READ,   64'h6,  SIZE_HALF,   '0, '0);
    send_op(OP_READ,   64'h1,  SIZE_HALF,   '0, '0);
    send_op(OP_WRITE,  64'h9,  SIZE_BYTE,   64'hffff_ffff_ffff_ffa5, '0);
    send_op(OP_POKE,   64'hf,  SIZE_DOUBLE, 64'h5a, '0);
    send_op(OP_READ,   64'h8,  SIZE_DOUBLE, '0, '0);
    send_op(OP_CHECK,  64'h100, SIZE_WORD,  '0, '0);
    send_op(OP_WRITE,  64'hc,  SIZE_WORD,   FullMask, '0);
    send_op(OpUnusedLo, 64'h0, SIZE_WORD,   FullMask, FullMask);
    send_op(OpUnusedHi, 64'h8, SIZE_DOUBLE, FullMask, FullMask);
    send_op(OP_DEFINE, 64'h0,  SIZE_WORD,   '0, '0);
    send_op(OP_READ,   64'h0,  SIZE_WORD,   '0, '0);
    send_op(OP_DEFINE, TopDouble, SIZE_DOUBLE, '0, FullMask);
    send_op(OP_WRITE,  TopDouble, SIZE_DOUBLE, 64'h8000_0000_0000_0001, '0);
    send_op(OP_READ,   TopDouble + 64'd4, SIZE_WORD, '0, '0);
    send_op(OP_POKE,   FullMask, SIZE_BYTE, FullMask, '0);
    send_op(OP_READ,   TopDouble, SIZE_DOUBLE, '0, '0);

    for (int n = 0; n < NumRandom; n++) begin
      if (n % 64 == 0) pacing = ($urandom_range(0, 3) != 0);
      send_access(random_access());
    end
    s_axis_tvalid_i <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    leftover = sb.outstanding();

    $display("accesses: %0d define, %0d read, %0d write, %0d poke, %0d check, %0d unused op",
             sb.ops_seen[OP_DEFINE], sb.ops_seen[OP_READ], sb.ops_seen[OP_WRITE],
             sb.ops_seen[OP_POKE], sb.ops_seen[OP_CHECK],
             sb.ops_seen[5] + sb.ops_seen[6] + sb.ops_seen[7]);
    $display("%0d results checked: %0d ok, %0d misaligned, %0d no register, %0d rejected",
             sb.replies_checked, sb.status_seen[STS_OK], sb.status_seen[STS_MISALIGNED],
             sb.status_seen[STS_NO_REG], sb.status_seen[STS_BAD]);
    if (sb.mismatches == 0 && leftover == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results never returned", sb.mismatches, leftover);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
